// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// Needs a clock and an active-low reset name at each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define TTS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition must never be seen outside reset.
`define TTS_NEVER(lbl, clk, rstn, cond, msg) \
  `TTS_ASSERT(lbl, clk, rstn, !(cond), msg)

`endif

// ===== rtl/tts_pkg.sv =====
// Shared types and constants of the template tag scanner.
// No dependencies; used by every rtl module.
package tts_pkg;

  localparam int unsigned LINE_BITS_DEF = 16;
  localparam int unsigned LINE_OUT_W    = 16;
  localparam int unsigned MAX_RES       = 3;
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    ROLE_TEXT = 3'd0,
    ROLE_NAME = 3'd1,
    ROLE_ARG  = 3'd2,
    ROLE_CALL = 3'd3,
    ROLE_ERR  = 3'd4
  } role_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_DIGIT    = 3'd1,
    ERR_NO_PAREN = 3'd2,
    ERR_NO_CLOSE = 3'd3,
    ERR_EOF      = 3'd4
  } err_e;

  typedef struct packed {
    logic [7:0]            ch;
    role_e                 role;
    err_e                  err;
    logic [LINE_OUT_W-1:0] line;
  } res_t;

  // All words caused by one input byte.
  typedef struct packed {
    res_t [0:MAX_RES-1] res;
    logic [1:0]         cnt;
  } bundle_t;

endpackage

// ===== rtl/tts_front.sv =====
// Front end: accepts bytes, runs the scanner state and builds the words of each byte.
// Depends on tts_pkg.
module tts_front
  import tts_pkg::*;
#(
  parameter int unsigned LINE_BITS = LINE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] char_i,
  input  logic       eof_i,
  output bundle_t    bundle_o
);

  localparam logic [1:0] MODE_TEXT = 2'd0;
  localparam logic [1:0] MODE_IDLE = 2'd1;
  localparam logic [1:0] MODE_NAME = 2'd2;
  localparam logic [1:0] MODE_ARGS = 2'd3;

  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
  localparam logic [LINE_BITS-1:0] LINE_TOP = {LINE_BITS{1'b1}};

  logic [1:0]           mode_q, mode_d;
  logic [7:0]           held_q, held_d;
  logic                 hv_q, hv_d;
  logic [LINE_BITS-1:0] line_q, line_d;
  logic                 stop_q, stop_d;

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) ||
           ((c >= CH_NL) && (c <= 8'h0C));
  endfunction

  function automatic logic [LINE_OUT_W-1:0] line_out(logic [LINE_BITS-1:0] l);
    logic [31:0] wide;
    wide = 32'(l);
    return wide[LINE_OUT_W-1:0];
  endfunction

  // Append one word unless three are already there.
  function automatic bundle_t put(bundle_t b, logic [7:0] ch, role_e r, err_e e,
                                  logic [LINE_OUT_W-1:0] ln);
    res_t w;
    w.ch   = ch;
    w.role = r;
    w.err  = e;
    w.line = ln;
    if (b.cnt != 2'(MAX_RES)) begin
      b.res[b.cnt] = w;
      b.cnt        = b.cnt + 2'd1;
    end
    return b;
  endfunction

  always_comb begin
    bundle_t b;
    logic    do_take;
    logic [7:0] c;
    b       = '0;
    do_take = 1'b1;
    c       = char_i;
    mode_d  = mode_q;
    held_d  = held_q;
    hv_d    = hv_q;
    line_d  = line_q;
    stop_d  = stop_q;

    if (!stop_q) begin
      // resolve a held byte against the new one
      if (hv_q) begin
        hv_d = 1'b0;
        unique case (mode_q)
          MODE_TEXT: begin
            if (c == CH_LBRACE) begin
              mode_d  = MODE_IDLE;
              do_take = 1'b0;
            end else begin
              b = put(b, held_q, ROLE_TEXT, ERR_NONE, line_out(line_d));
            end
          end
          MODE_IDLE: begin
            if (c == CH_GT) begin
              mode_d  = MODE_TEXT;
              do_take = 1'b0;
            end else begin
              mode_d = MODE_NAME;
              b = put(b, held_q, ROLE_NAME, ERR_NONE, line_out(line_d));
            end
          end
          MODE_NAME: begin
            if (c == CH_GT) begin
              b = put(b, 8'h00, ROLE_ERR, ERR_NO_PAREN, line_out(line_d));
              stop_d  = 1'b1;
              do_take = 1'b0;
            end else begin
              b = put(b, held_q, ROLE_NAME, ERR_NONE, line_out(line_d));
            end
          end
          default: begin
            if (held_q == CH_RPAREN && c == CH_SEMI) begin
              b = put(b, 8'h00, ROLE_CALL, ERR_NONE, line_out(line_d));
              mode_d  = MODE_IDLE;
              do_take = 1'b0;
            end else if (held_q == CH_RBRACE && c == CH_GT) begin
              b = put(b, 8'h00, ROLE_ERR, ERR_NO_CLOSE, line_out(line_d));
              stop_d  = 1'b1;
              do_take = 1'b0;
            end else begin
              b = put(b, held_q, ROLE_ARG, ERR_NONE, line_out(line_d));
            end
          end
        endcase
      end

      if (do_take) begin
        unique case (mode_d)
          MODE_TEXT: begin
            if (c == CH_LT) begin
              held_d = c;
              hv_d   = 1'b1;
            end else begin
              if (c == CH_NL && line_d != LINE_TOP) line_d = line_d + LINE_ONE;
              b = put(b, c, ROLE_TEXT, ERR_NONE, line_out(line_d));
            end
          end
          MODE_ARGS: begin
            if (c == CH_RPAREN || c == CH_RBRACE) begin
              held_d = c;
              hv_d   = 1'b1;
            end else begin
              b = put(b, c, ROLE_ARG, ERR_NONE, line_out(line_d));
            end
          end
          default: begin
            // between calls or inside a name
            if (mode_d == MODE_IDLE && c == CH_NL) begin
              if (line_d != LINE_TOP) line_d = line_d + LINE_ONE;
            end else if (mode_d == MODE_IDLE && c != CH_RBRACE && is_space(c)) begin
              // whitespace between calls is dropped
            end else if (mode_d == MODE_IDLE && c >= CH_ZERO && c <= CH_NINE) begin
              b = put(b, 8'h00, ROLE_ERR, ERR_DIGIT, line_out(line_d));
              stop_d = 1'b1;
              hv_d   = 1'b0;
            end else if (mode_d == MODE_IDLE && c == CH_RBRACE) begin
              held_d = c;
              hv_d   = 1'b1;
            end else begin
              mode_d = MODE_NAME;
              if (c == CH_LPAREN) begin
                mode_d = MODE_ARGS;
              end else if (c == CH_RBRACE) begin
                held_d = c;
                hv_d   = 1'b1;
              end else begin
                b = put(b, c, ROLE_NAME, ERR_NONE, line_out(line_d));
              end
            end
          end
        endcase
      end

      // end of file: flush the held byte, then complain if still in a block
      if (eof_i && !stop_d) begin
        if (hv_d) begin
          hv_d = 1'b0;
          unique case (mode_d)
            MODE_TEXT: b = put(b, held_d, ROLE_TEXT, ERR_NONE, line_out(line_d));
            MODE_ARGS: b = put(b, held_d, ROLE_ARG, ERR_NONE, line_out(line_d));
            default:   b = put(b, held_d, ROLE_NAME, ERR_NONE, line_out(line_d));
          endcase
        end
        if (mode_d != MODE_TEXT) begin
          b = put(b, 8'h00, ROLE_ERR, ERR_EOF, line_out(line_d));
        end
      end
    end

    if (eof_i) begin
      mode_d = MODE_TEXT;
      held_d = 8'h00;
      hv_d   = 1'b0;
      line_d = LINE_ONE;
      stop_d = 1'b0;
    end

    bundle_o = b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_TEXT;
      held_q <= 8'h00;
      hv_q   <= 1'b0;
      line_q <= LINE_ONE;
      stop_q <= 1'b0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      held_q <= held_d;
      hv_q   <= hv_d;
      line_q <= line_d;
      stop_q <= stop_d;
    end
  end

endmodule

// ===== rtl/tts_queue.sv =====
// Short queue of per-byte word bundles between front and back end.
// Depends on tts_pkg.
module tts_queue
  import tts_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t push_data_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    valid_o,
  output bundle_t data_o
);

  bundle_t           mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== rtl/tts_back.sv =====
// Back end: sends the words of queued bundles one per cycle while ready_i is high.
// Depends on tts_pkg.
module tts_back
  import tts_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_valid_i,
  input  bundle_t q_data_i,
  output logic    q_pop_o,
  output logic    valid_o,
  input  logic    ready_i,
  output res_t    word_o,
  output logic    last_o
);

  bundle_t    bundle_q;
  logic [1:0] idx_q;
  logic       busy_q;
  logic       done;

  assign valid_o = busy_q;
  assign word_o  = bundle_q.res[idx_q];
  assign last_o  = (idx_q == bundle_q.cnt - 2'd1);
  // current bundle finished (or none held): next one may load now
  assign done    = !busy_q || (ready_i && last_o);
  assign q_pop_o = done && q_valid_i;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) bundle_q <= q_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else if (done) begin
      busy_q <= q_valid_i;
      idx_q  <= 2'd0;
    end else if (ready_i) begin
      idx_q <= idx_q + 2'd1;
    end
  end

endmodule

// ===== rtl/template_tag_scanner_top.sv =====
// Template tag scanner. Takes one template byte per cycle on the slave stream while
// the queue is not full and tags it as text, name or argument, adds a call marker
// after each ');' and an error word on a bad block; '<{', '}>', '(' and ');' and
// blank space between calls give no word. A byte gives zero to three words and the
// master stream sends one word per cycle while the sink is ready, so input runs at
// one byte per cycle while each byte gives at most one word; bytes that release a
// held byte, close a call or end a file inside a block can give more. A four-deep
// queue of per-byte bundles absorbs such bursts. Words pass the queue and a bundle
// register. After an error nothing is sent until the byte after end_of_file.
// Depends on tts_pkg, tts_front, tts_queue, tts_back.
module template_tag_scanner_top
  import tts_pkg::*;
#(
  parameter int unsigned LINE_BITS = LINE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_in
  input  logic        s_axis_tlast_i,   // end_of_file
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [7:0] char_out, [10:8] role,
                                        // [13:11] error_code, [29:14] line_number
  output logic        m_axis_tlast_o    // last
);

  logic    accept, q_full, q_valid, q_pop, push;
  bundle_t front_bundle, q_data;
  res_t    word;

  assign s_axis_tready_o = !q_full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign push            = accept && (front_bundle.cnt != 2'd0);

  tts_front #(
    .LINE_BITS(LINE_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .char_i   (s_axis_tdata_i),
    .eof_i    (s_axis_tlast_i),
    .bundle_o (front_bundle)
  );

  tts_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_bundle),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  tts_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .q_pop_o   (q_pop),
    .valid_o   (m_axis_tvalid_o),
    .ready_i   (m_axis_tready_i),
    .word_o    (word),
    .last_o    (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {2'b00, word.line, word.err, word.role, word.ch};

endmodule

// ===== rtl/tts_checker.sv =====
// Port-level checker for the template tag scanner, bound to the top level.
// Depends on tts_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tts_checker
  import tts_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  logic [7:0] out_ch;
  logic [2:0] out_role;
  logic [2:0] out_err;
  logic       out_stall;
  logic       out_marker;

  assign out_ch     = m_axis_tdata_o[7:0];
  assign out_role   = m_axis_tdata_o[10:8];
  assign out_err    = m_axis_tdata_o[13:11];
  assign out_stall  = m_axis_tvalid_o && !m_axis_tready_i;
  assign out_marker = (out_role == ROLE_CALL) || (out_role == ROLE_ERR);

  `TTS_ASSERT(a_out_hold, clk_i, rst_ni,
              out_stall |=> m_axis_tvalid_o && $stable({m_axis_tlast_o, m_axis_tdata_o}),
              "output word changed while stalled")
  `TTS_ASSERT(a_err_code, clk_i, rst_ni,
              m_axis_tvalid_o |-> ((out_role == ROLE_ERR) == (out_err != ERR_NONE)),
              "error code disagrees with role")
  `TTS_ASSERT(a_marker_zero, clk_i, rst_ni,
              m_axis_tvalid_o && out_marker |-> out_ch == 8'h00,
              "marker word carries a byte")
  `TTS_NEVER(a_err_last, clk_i, rst_ni,
             m_axis_tvalid_o && (out_role == ROLE_ERR) && !m_axis_tlast_o,
             "error word not last of its byte")

endmodule

bind template_tag_scanner_top tts_checker u_tts_checker (.*);
